// ===== rtl/srde_pkg.sv =====
// ----------------------------------------------------------------------------
// srde_pkg: shared types and constants for the signed radix digit emitter
// Command and status bundles between controller and datapath, field widths,
// sign bytes and divider sizing.
// ----------------------------------------------------------------------------
package srde_pkg;

	localparam int NUM_W      = 32;
	localparam int RADIX_W    = 7;
	localparam int SLOT_W     = 6;
	localparam int CHAR_W     = 8;

	// digit buffer: at most one digit per magnitude bit
	localparam int DIG_DEPTH  = 32;
	localparam int DIG_PTR_W  = 5;

	// restoring divider: quotient bits retired per cycle
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = NUM_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic [CHAR_W-1:0] SIGN_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] SIGN_MINUS = 8'h2D;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_CONVERT = 1'b1;

	typedef enum logic [1:0] {
		RD_A,
		RD_B,
		RD_DIG
	} rd_sel_t;

	typedef enum logic [1:0] {
		OUT_SIGN,
		OUT_DIGIT,
		OUT_INVALID
	} out_src_t;

	typedef struct packed {
		logic     alpha_wr;
		logic     num_load;
		logic     a_clr;
		logic     a_inc;
		logic     b_load;
		logic     b_inc;
		logic     sym_load;
		rd_sel_t  rd_sel;
		logic     div_init;
		logic     div_step;
		logic     push;
		logic     ptr_inc;
		logic     ptr_dec;
		logic     out_load;
		out_src_t out_src;
	} srde_cmd_t;

	typedef struct packed {
		logic radix_in_range;
		logic sym_is_sign;
		logic sym_eq;
		logic a_at_end;
		logic b_at_end;
		logic div_done;
		logic quot_zero;
		logic ptr_full;
		logic ptr_zero;
		logic neg;
	} srde_sts_t;

endpackage

// ===== rtl/srde_ram.sv =====
// ----------------------------------------------------------------------------
// srde_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/srde_ctrl.sv =====
// ----------------------------------------------------------------------------
// srde_ctrl: sequencer for the signed radix digit emitter
// Caches base validity, walks the alphabet check, runs the divider per digit
// and paces the output register.
// ----------------------------------------------------------------------------
module srde_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_action,
	input  logic                cfg_we,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  srde_pkg::srde_sts_t sts,
	output srde_pkg::srde_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VSTART,
		ST_VRDA,
		ST_VCAPA,
		ST_VRDB,
		ST_VCMP,
		ST_INV,
		ST_CINIT,
		ST_CDIV,
		ST_CPUSH,
		ST_ESIGN,
		ST_ERD,
		ST_EPUT
	} state_t;

	state_t state_q, state_d;
	logic   known_q, ok_q, m_tvalid_q;
	logic   accept, out_free, val_pass, val_fail;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = srde_pkg::RD_DIG;
		state_d    = state_q;
		val_pass   = 1'b0;
		val_fail   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_action == srde_pkg::ACT_LOAD) begin
						cmd.alpha_wr = 1'b1;
					end else begin
						cmd.num_load = 1'b1;
						if (!known_q) begin
							state_d = ST_VSTART;
						end else if (ok_q) begin
							state_d = ST_CINIT;
						end else begin
							state_d = ST_INV;
						end
					end
				end
			end
			ST_VSTART: begin
				if (!sts.radix_in_range) begin
					val_fail = 1'b1;
					state_d  = ST_INV;
				end else begin
					cmd.a_clr = 1'b1;
					state_d   = ST_VRDA;
				end
			end
			ST_VRDA: begin
				cmd.rd_sel = srde_pkg::RD_A;
				state_d    = ST_VCAPA;
			end
			ST_VCAPA: begin
				cmd.rd_sel   = srde_pkg::RD_A;
				cmd.sym_load = 1'b1;
				if (sts.sym_is_sign) begin
					val_fail = 1'b1;
					state_d  = ST_INV;
				end else if (sts.a_at_end) begin
					val_pass = 1'b1;
					state_d  = ST_CINIT;
				end else begin
					cmd.b_load = 1'b1;
					state_d    = ST_VRDB;
				end
			end
			ST_VRDB: begin
				cmd.rd_sel = srde_pkg::RD_B;
				state_d    = ST_VCMP;
			end
			ST_VCMP: begin
				cmd.rd_sel = srde_pkg::RD_B;
				if (sts.sym_eq) begin
					val_fail = 1'b1;
					state_d  = ST_INV;
				end else if (sts.b_at_end) begin
					cmd.a_inc = 1'b1;
					state_d   = ST_VRDA;
				end else begin
					cmd.b_inc = 1'b1;
					state_d   = ST_VRDB;
				end
			end
			ST_INV: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = srde_pkg::OUT_INVALID;
					state_d      = ST_IDLE;
				end
			end
			ST_CINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_CDIV;
			end
			ST_CDIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_CPUSH;
				end
			end
			ST_CPUSH: begin
				cmd.push = 1'b1;
				if (!sts.quot_zero && !sts.ptr_full) begin
					cmd.ptr_inc  = 1'b1;
					cmd.div_init = 1'b1;
					state_d      = ST_CDIV;
				end else if (sts.neg) begin
					state_d = ST_ESIGN;
				end else begin
					state_d = ST_ERD;
				end
			end
			ST_ESIGN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = srde_pkg::OUT_SIGN;
					state_d      = ST_ERD;
				end
			end
			ST_ERD: begin
				state_d = ST_EPUT;
			end
			ST_EPUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = srde_pkg::OUT_DIGIT;
					if (sts.ptr_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.ptr_dec = 1'b1;
						state_d     = ST_ERD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			known_q    <= 1'b0;
			ok_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (val_pass || val_fail) begin
				known_q <= 1'b1;
				ok_q    <= val_pass;
			end
			// any change to radix or alphabet forces a fresh check
			if (cfg_we || cmd.alpha_wr) begin
				known_q <= 1'b0;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten while a request is pending");

	a_inv_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INV) |-> !ok_q)
		else $error("invalid-base result issued with a base marked valid");

endmodule

// ===== rtl/srde_dpath.sv =====
// ----------------------------------------------------------------------------
// srde_dpath: datapath of the signed radix digit emitter
// Radix register, alphabet RAM, check counters, restoring divider,
// digit buffer and output register.
// ----------------------------------------------------------------------------
module srde_dpath #(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [srde_pkg::RADIX_W-1:0]         cfg_radix,
	input  logic [srde_pkg::SLOT_W-1:0]          slot,
	input  logic [srde_pkg::CHAR_W-1:0]          symbol,
	input  logic signed [srde_pkg::NUM_W-1:0]    number,
	input  srde_pkg::srde_cmd_t                  cmd,
	output srde_pkg::srde_sts_t                  sts,
	output logic [srde_pkg::CHAR_W-1:0]          out_char,
	output logic                                 out_status,
	output logic                                 out_last
);

	localparam int AW = $clog2(MAX_SYMBOLS);
	localparam logic [8:0] MAX_W = 9'(MAX_SYMBOLS);

	logic [srde_pkg::RADIX_W-1:0]   radix_q;
	logic [srde_pkg::RADIX_W-1:0]   a_q, b_q;
	logic [srde_pkg::CHAR_W-1:0]    sym_a_q;
	logic                           neg_q;
	logic [srde_pkg::NUM_W-1:0]     mag_q, num_u, q_nxt;
	logic [srde_pkg::RADIX_W-1:0]   rem_q, r_nxt;
	logic [srde_pkg::RADIX_W:0]     trial;
	logic [srde_pkg::DIV_CNT_W-1:0] step_q;
	logic [srde_pkg::RADIX_W-1:0]   dig_q [srde_pkg::DIG_DEPTH];
	logic [srde_pkg::DIG_PTR_W-1:0] ptr_q;
	logic [srde_pkg::CHAR_W-1:0]    out_char_q;
	logic                           out_status_q, out_last_q;
	logic                           ram_we;
	logic [AW-1:0]                  ram_raddr;
	logic [srde_pkg::CHAR_W-1:0]    ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
		end else if (cfg_we) begin
			radix_q <= cfg_radix;
		end
	end

	// slots past the alphabet size are dropped
	assign ram_we = cmd.alpha_wr && ({3'b000, slot} < MAX_W);

	always_comb begin
		unique case (cmd.rd_sel)
			srde_pkg::RD_A:   ram_raddr = AW'(a_q);
			srde_pkg::RD_B:   ram_raddr = AW'(b_q);
			srde_pkg::RD_DIG: ram_raddr = AW'(dig_q[ptr_q]);
			default:          ram_raddr = AW'(dig_q[ptr_q]);
		endcase
	end

	srde_ram #(
		.WIDTH (srde_pkg::CHAR_W),
		.DEPTH (MAX_SYMBOLS)
	) u_alpha (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(slot)),
		.wdata (symbol),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// DIV_BITS restoring steps per cycle; remainder stays below radix
	assign num_u = number;

	always_comb begin
		r_nxt = rem_q;
		q_nxt = mag_q;
		trial = '0;
		for (int i = 0; i < srde_pkg::DIV_BITS; i++) begin
			trial = {r_nxt, q_nxt[srde_pkg::NUM_W-1]};
			q_nxt = {q_nxt[srde_pkg::NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				trial    = trial - {1'b0, radix_q};
				q_nxt[0] = 1'b1;
			end
			r_nxt = trial[srde_pkg::RADIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.a_clr) begin
			a_q <= '0;
		end else if (cmd.a_inc) begin
			a_q <= a_q + 7'd1;
		end
		if (cmd.b_load) begin
			b_q <= a_q + 7'd1;
		end else if (cmd.b_inc) begin
			b_q <= b_q + 7'd1;
		end
		if (cmd.sym_load) begin
			sym_a_q <= ram_rdata;
		end
		if (cmd.num_load) begin
			neg_q <= num_u[srde_pkg::NUM_W-1];
			mag_q <= num_u[srde_pkg::NUM_W-1] ? (32'd0 - num_u) : num_u;
		end else if (cmd.div_step) begin
			mag_q <= q_nxt;
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= r_nxt;
			step_q <= step_q + 1'b1;
		end
		if (cmd.push) begin
			dig_q[ptr_q] <= rem_q;
		end
		if (cmd.num_load) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + 1'b1;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - 1'b1;
		end
		if (cmd.out_load) begin
			case (cmd.out_src)
				srde_pkg::OUT_SIGN: begin
					out_char_q   <= srde_pkg::SIGN_MINUS;
					out_status_q <= 1'b0;
					out_last_q   <= 1'b0;
				end
				srde_pkg::OUT_DIGIT: begin
					out_char_q   <= ram_rdata;
					out_status_q <= 1'b0;
					out_last_q   <= (ptr_q == '0);
				end
				default: begin
					out_char_q   <= '0;
					out_status_q <= 1'b1;
					out_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign sts.radix_in_range = (radix_q >= 7'd2) && ({2'b00, radix_q} <= MAX_W);
	assign sts.sym_is_sign    = (ram_rdata == srde_pkg::SIGN_PLUS) ||
	                            (ram_rdata == srde_pkg::SIGN_MINUS);
	assign sts.sym_eq         = (ram_rdata == sym_a_q);
	assign sts.a_at_end       = ((a_q + 7'd1) == radix_q);
	assign sts.b_at_end       = ((b_q + 7'd1) == radix_q);
	assign sts.div_done       = (step_q == srde_pkg::DIV_CNT_W'(srde_pkg::DIV_CYCLES - 1));
	assign sts.quot_zero      = (mag_q == '0);
	assign sts.ptr_full       = &ptr_q;
	assign sts.ptr_zero       = (ptr_q == '0);
	assign sts.neg            = neg_q;

	assign out_char   = out_char_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	a_ptr_no_wrap_up: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ptr_inc |-> !(&ptr_q))
		else $error("digit buffer overflow");

	a_ptr_no_wrap_down: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ptr_dec |-> (ptr_q != '0))
		else $error("digit pointer stepped below the first digit");

endmodule

// ===== rtl/signed_radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter: signed integer to text in a loadable alphabet
// Top level: stream unpacking, controller and datapath.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries requests. tuser = action: load writes symbol at slot into the
//   alphabet and yields nothing; convert turns number into characters.
//   m_* returns one character per beat: tuser = status (1 = base invalid,
//   tdata 0), tlast marks the final character of a conversion.
//   cfg_* writes the radix; write it only while the block is idle.
// Sequencing
//   The first convert after a load or a radix write re-checks the alphabet,
//   all pairs compared through the single RAM read port. The result is cached.
//   Digits are divided out least significant first, each by eight 4-bit
//   restoring divider steps and a push, then sent most significant first,
//   each after a fetch of its symbol; a minus sign goes before them. Up to 32
//   digits in radix 2. A cached invalid base yields one invalid character.
//   No new request is taken until a conversion has loaded its last character.
// Reset and stalls
//   Reset clears the radix to 0 (base invalid) and all control state; the
//   alphabet holds garbage until written. The output is one register: when
//   the receiver stalls the sequencer waits, and the next request is taken
//   while the final character still sits in that register.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter #(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // slot[5:0], symbol[13:6], number[45:14], zero pad
	input  logic [0:0]  s_tuser,   // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_char[7:0]
	output logic [0:0]  m_tuser,   // status[0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data   // radix
);

	srde_pkg::srde_cmd_t cmd;
	srde_pkg::srde_sts_t sts;
	logic                cfg_we;

	// radix writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	srde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_action (s_tuser[0]),
		.cfg_we   (cfg_we),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srde_dpath #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_radix  (cfg_data),
		.slot       (s_tdata[5:0]),
		.symbol     (s_tdata[13:6]),
		.number     (s_tdata[45:14]),
		.cmd        (cmd),
		.sts        (sts),
		.out_char   (m_tdata),
		.out_status (m_tuser[0]),
		.out_last   (m_tlast)
	);

endmodule
